FILE: src/porous_drag_coefficient_update_defines.svh
// assertion macros for the porous drag coefficient update block
`ifndef POROUS_DRAG_COEFFICIENT_UPDATE_DEFINES_SVH
`define POROUS_DRAG_COEFFICIENT_UPDATE_DEFINES_SVH

// same-cycle implication, idle during reset
`define PDCU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define PDCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pdcu_pkg.sv
// shared types, constants and clamp helper of the porous drag coefficient update
`default_nettype none
package pdcu_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned CFG_DATA_W     = 60;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam logic [31:0] DENSITY_RST    = 32'h0001_0000;

    typedef struct packed {
        logic        [30:0] cell_volume;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] diag_in;
        logic signed [31:0] source_in_x;
        logic signed [31:0] source_in_y;
        logic signed [31:0] source_in_z;
    } t_cell_item;

    typedef struct packed {
        logic signed [31:0] diag_out;
        logic signed [31:0] source_out_x;
        logic signed [31:0] source_out_y;
        logic signed [31:0] source_out_z;
        logic               saturated;
    } t_res_item;

    typedef struct packed {
        logic signed [67:0] val;
        logic               hit;
    } t_clamp;

    // clamp to a signed range of the given width
    function automatic t_clamp sat_to(input logic signed [67:0] v, input int unsigned bits);
        t_clamp c;
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi    = (68'sd1 <<< (bits - 1)) - 68'sd1;
        lo    = -hi - 68'sd1;
        c.val = v;
        c.hit = 1'b0;
        if (v > hi) begin
            c.val = hi;
            c.hit = 1'b1;
        end else if (v < lo) begin
            c.val = lo;
            c.hit = 1'b1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/pdcu_cell_if.sv
// cell channel: valid/ready with one cell item
`default_nettype none
interface pdcu_cell_if;
    logic                 valid;
    logic                 ready;
    pdcu_pkg::t_cell_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/pdcu_res_if.sv
// result channel: valid/ready with one updated diagonal and source
`default_nettype none
interface pdcu_res_if;
    logic                valid;
    logic                ready;
    pdcu_pkg::t_res_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/porous_drag_coefficient_update.sv
// top level: pipelined porous drag coefficient update kernel
//
//  channel   dir  handshake            payload
//  i_cell    in   valid/ready          volume, velocity, diagonal, source
//  o_res     out  valid/ready          diagonal, source, saturated flag
//  i_cfg_*   in   write enable only    register index, 60-bit data
//
// one cell per cycle sustained while o_res is not stalled, 49 stages
// depth is set by the bit-per-stage square root (32 stages) and split multiplies
// each stage loads when it is empty or its content moves on, so bubbles close up
// a stalled output freezes only the full stages behind it; nothing is lost or repeated
// synchronous active-low reset clears valid bits and restores register defaults
`default_nettype none
`include "porous_drag_coefficient_update_defines.svh"
module porous_drag_coefficient_update #(
    parameter int unsigned DATA_WIDTH = pdcu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    pdcu_cell_if.sink                               i_cell,
    pdcu_res_if.source                              o_res,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [pdcu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pdcu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // register indexes
    localparam logic [2:0] CFG_DENSITY = 3'd0;
    localparam logic [2:0] CFG_ALPHA_X = 3'd1;
    localparam logic [2:0] CFG_ALPHA_Y = 3'd2;
    localparam logic [2:0] CFG_ALPHA_Z = 3'd3;
    localparam logic [2:0] CFG_BETA_X  = 3'd4;
    localparam logic [2:0] CFG_BETA_Y  = 3'd5;
    localparam logic [2:0] CFG_BETA_Z  = 3'd6;

    // stage map
    localparam int unsigned ST_SQ  = 1;             // velocity squares
    localparam int unsigned ST_SUM = 2;             // |U|^2
    localparam int unsigned ST_RT0 = 3;             // first square root step
    localparam int unsigned RT_N   = 32;            // one root bit per stage
    localparam int unsigned ST_T   = ST_RT0 + RT_N; // alpha + beta*|U|
    localparam int unsigned ST_CDP = ST_T + 1;      // t*rho partials
    localparam int unsigned ST_CDS = ST_T + 2;      // t*rho combine
    localparam int unsigned ST_CDC = ST_T + 3;      // Cd clamp
    localparam int unsigned ST_TR  = ST_T + 4;      // trace and M
    localparam int unsigned ST_MP  = ST_T + 5;      // V*tr and M*U partials
    localparam int unsigned ST_MS  = ST_T + 6;      // combine
    localparam int unsigned ST_MC  = ST_T + 7;      // clamp
    localparam int unsigned ST_DF  = ST_T + 8;      // diagonal result, row sums
    localparam int unsigned ST_W   = ST_T + 9;      // row clamp
    localparam int unsigned ST_WP  = ST_T + 10;     // V*w partials
    localparam int unsigned ST_WS  = ST_T + 11;     // combine
    localparam int unsigned ST_SC  = ST_T + 12;     // clamp
    localparam int unsigned ST_SF  = ST_T + 13;     // source result
    localparam int unsigned NSTG   = ST_SF + 1;

    typedef struct packed {
        logic [30:0]       vol;
        logic [2:0][31:0]  u;
        logic [31:0]       dgi;
        logic [2:0][31:0]  srci;
        logic [2:0][63:0]  sqp;
        logic [63:0]       rn;
        logic [63:0]       rr;
        logic [8:0][53:0]  t;
        logic [8:0][58:0]  cpl;
        logic [8:0][59:0]  cph;
        logic [8:0][60:0]  cdr;
        logic [8:0][47:0]  cd;
        logic [49:0]       tr;
        logic [8:0][50:0]  m;
        logic [55:0]       dpl;
        logic [56:0]       dph;
        logic [65:0]       draw;
        logic [59:0]       dterm;
        logic [8:0][57:0]  mpl;
        logic [8:0][57:0]  mph;
        logic [8:0][66:0]  mraw;
        logic [8:0][59:0]  mu;
        logic [2:0][61:0]  acc;
        logic [2:0][47:0]  w;
        logic [2:0][54:0]  wpl;
        logic [2:0][55:0]  wph;
        logic [2:0][63:0]  sraw;
        logic [2:0][59:0]  sterm;
        logic [31:0]       dout;
        logic [2:0][31:0]  sout;
        logic              sat;
    } t_pipe;

    logic [31:0]      r_density;
    logic [5:0][59:0] r_coef;       // alpha rows x,y,z then beta rows x,y,z
    logic [NSTG-1:0]  r_vld;
    t_pipe            r_pipe [NSTG];
    t_pipe            n_pipe [NSTG];
    logic [NSTG-1:0]  ld;           // stage may load this cycle

    // one pipeline step; k selects which slice of the work this stage does
    function automatic t_pipe stage_fn(input int unsigned k, input t_pipe p,
                                       input logic [31:0] rho, input logic [5:0][59:0] cf);
        t_pipe              q;
        logic [31:0]        mg;
        logic [63:0]        bt;
        logic [64:0]        trial;
        logic signed [19:0] a20;
        logic signed [19:0] b20;
        logic signed [52:0] prod53;
        logic signed [53:0] t54;
        logic signed [59:0] ph60;
        logic signed [86:0] f87;
        logic signed [49:0] tr50;
        logic signed [50:0] m51;
        logic signed [50:0] trx;
        logic signed [56:0] d57;
        logic signed [57:0] mp58;
        logic signed [81:0] f82;
        logic signed [82:0] f83;
        logic signed [61:0] acc62;
        logic signed [55:0] wp56;
        logic signed [79:0] f80;
        logic signed [60:0] r61;
        pdcu_pkg::t_clamp   c;
        int unsigned        it;
        q = p;
        if (k == ST_SQ) begin
            for (int i = 0; i < 3; i++) begin
                mg = p.u[i][31] ? (~p.u[i] + 32'd1) : p.u[i];
                q.sqp[i] = {32'd0, mg} * {32'd0, mg};
            end
        end else if (k == ST_SUM) begin
            q.rn = p.sqp[0] + p.sqp[1] + p.sqp[2];
            q.rr = '0;
        end else if (k >= ST_RT0 && k < ST_T) begin
            // restoring square root, two radicand bits per step
            it    = k - ST_RT0;
            bt    = 64'd1 << (62 - 2 * it);
            trial = {1'b0, p.rr} + {1'b0, bt};
            if ({1'b0, p.rn} >= trial) begin
                q.rn = p.rn - trial[63:0];
                q.rr = (p.rr >> 1) + bt;
            end else begin
                q.rr = p.rr >> 1;
            end
        end else if (k == ST_T) begin
            mg = p.rr[31:0];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    a20    = $signed(cf[i][20 * j +: 20]);
                    b20    = $signed(cf[3 + i][20 * j +: 20]);
                    prod53 = b20 * $signed({1'b0, mg});
                    t54    = $signed({{18{a20[19]}}, a20, 16'd0}) + 54'(prod53);
                    q.t[3 * i + j] = t54;
                end
            end
        end else if (k == ST_CDP) begin
            for (int x = 0; x < 9; x++) begin
                q.cpl[x] = 59'(p.t[x][26:0]) * 59'(rho);
                ph60     = $signed(p.t[x][53:27]) * $signed({1'b0, rho});
                q.cph[x] = ph60;
            end
        end else if (k == ST_CDS) begin
            for (int x = 0; x < 9; x++) begin
                f87      = $signed({p.cph[x], 27'd0}) + $signed({28'd0, p.cpl[x]});
                q.cdr[x] = f87[86:26];
            end
        end else if (k == ST_CDC) begin
            for (int x = 0; x < 9; x++) begin
                c       = pdcu_pkg::sat_to(68'($signed(p.cdr[x])), 48);
                q.cd[x] = c.val[47:0];
                q.sat   = q.sat | c.hit;
            end
        end else if (k == ST_TR) begin
            tr50 = 50'($signed(p.cd[0])) + 50'($signed(p.cd[4])) + 50'($signed(p.cd[8]));
            q.tr = tr50;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    trx = (i == j) ? 51'(tr50) : 51'sd0;
                    m51 = 51'($signed(p.cd[3 * i + j])) - trx;
                    q.m[3 * i + j] = m51;
                end
            end
        end else if (k == ST_MP) begin
            q.dpl = 56'(p.vol) * 56'(p.tr[24:0]);
            d57   = $signed(p.tr[49:25]) * $signed({1'b0, p.vol});
            q.dph = d57;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    mp58 = $signed({1'b0, p.m[3 * i + j][24:0]}) * $signed(p.u[j]);
                    q.mpl[3 * i + j] = mp58;
                    mp58 = $signed(p.m[3 * i + j][50:25]) * $signed(p.u[j]);
                    q.mph[3 * i + j] = mp58;
                end
            end
        end else if (k == ST_MS) begin
            f82    = $signed({p.dph, 25'd0}) + $signed({26'd0, p.dpl});
            q.draw = f82[81:16];
            for (int x = 0; x < 9; x++) begin
                f83       = $signed({p.mph[x], 25'd0}) + 83'($signed(p.mpl[x]));
                q.mraw[x] = f83[82:16];
            end
        end else if (k == ST_MC) begin
            c       = pdcu_pkg::sat_to(68'($signed(p.draw)), 60);
            q.dterm = c.val[59:0];
            q.sat   = q.sat | c.hit;
            for (int x = 0; x < 9; x++) begin
                c       = pdcu_pkg::sat_to(68'($signed(p.mraw[x])), 60);
                q.mu[x] = c.val[59:0];
                q.sat   = q.sat | c.hit;
            end
        end else if (k == ST_DF) begin
            r61    = 61'($signed(p.dgi)) + 61'($signed(p.dterm));
            c      = pdcu_pkg::sat_to(68'(r61), DATA_WIDTH);
            q.dout = c.val[31:0];
            q.sat  = q.sat | c.hit;
            for (int i = 0; i < 3; i++) begin
                acc62 = 62'($signed(p.mu[3 * i])) + 62'($signed(p.mu[3 * i + 1]))
                      + 62'($signed(p.mu[3 * i + 2]));
                q.acc[i] = acc62;
            end
        end else if (k == ST_W) begin
            for (int i = 0; i < 3; i++) begin
                c      = pdcu_pkg::sat_to(68'($signed(p.acc[i])), 48);
                q.w[i] = c.val[47:0];
                q.sat  = q.sat | c.hit;
            end
        end else if (k == ST_WP) begin
            for (int i = 0; i < 3; i++) begin
                q.wpl[i] = 55'(p.w[i][23:0]) * 55'(p.vol);
                wp56     = $signed(p.w[i][47:24]) * $signed({1'b0, p.vol});
                q.wph[i] = wp56;
            end
        end else if (k == ST_WS) begin
            for (int i = 0; i < 3; i++) begin
                f80       = $signed({p.wph[i], 24'd0}) + $signed({25'd0, p.wpl[i]});
                q.sraw[i] = f80[79:16];
            end
        end else if (k == ST_SC) begin
            for (int i = 0; i < 3; i++) begin
                c          = pdcu_pkg::sat_to(68'($signed(p.sraw[i])), 60);
                q.sterm[i] = c.val[59:0];
                q.sat      = q.sat | c.hit;
            end
        end else if (k == ST_SF) begin
            for (int i = 0; i < 3; i++) begin
                r61       = 61'($signed(p.srci[i])) - 61'($signed(p.sterm[i]));
                c         = pdcu_pkg::sat_to(68'(r61), DATA_WIDTH);
                q.sout[i] = c.val[31:0];
                q.sat     = q.sat | c.hit;
            end
        end
        return q;
    endfunction

    // configuration writes, index seven is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= pdcu_pkg::DENSITY_RST;
            r_coef    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DENSITY: r_density <= i_cfg_data[31:0];
                CFG_ALPHA_X: r_coef[0] <= i_cfg_data;
                CFG_ALPHA_Y: r_coef[1] <= i_cfg_data;
                CFG_ALPHA_Z: r_coef[2] <= i_cfg_data;
                CFG_BETA_X:  r_coef[3] <= i_cfg_data;
                CFG_BETA_Y:  r_coef[4] <= i_cfg_data;
                CFG_BETA_Z:  r_coef[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry stage captures the cell
    always_comb begin
        n_pipe[0]         = '0;
        n_pipe[0].vol     = i_cell.data.cell_volume;
        n_pipe[0].u[0]    = i_cell.data.vel_x;
        n_pipe[0].u[1]    = i_cell.data.vel_y;
        n_pipe[0].u[2]    = i_cell.data.vel_z;
        n_pipe[0].dgi     = i_cell.data.diag_in;
        n_pipe[0].srci[0] = i_cell.data.source_in_x;
        n_pipe[0].srci[1] = i_cell.data.source_in_y;
        n_pipe[0].srci[2] = i_cell.data.source_in_z;
    end

    // load chain: a stage loads when empty or when its content is taken
    assign ld[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_ld
        assign ld[k] = !r_vld[k] || ld[k+1];
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_stage
        always_comb n_pipe[k] = stage_fn(k, r_pipe[k-1], r_density, r_coef);
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_data
        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_cell.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_cell.ready = ld[0];

    // last stage is the output register
    assign o_res.valid             = r_vld[NSTG-1];
    assign o_res.data.diag_out     = r_pipe[NSTG-1].dout;
    assign o_res.data.source_out_x = r_pipe[NSTG-1].sout[0];
    assign o_res.data.source_out_y = r_pipe[NSTG-1].sout[1];
    assign o_res.data.source_out_z = r_pipe[NSTG-1].sout[2];
    assign o_res.data.saturated    = r_pipe[NSTG-1].sat;

    // a transfer in always lands in the entry stage
    `PDCU_ASSERT_NEXT(a_entry_load, i_cell.valid && i_cell.ready, r_vld[0],
        "accepted cell missing from entry stage")
    // back-pressure only when every stage is full behind a stalled result
    `PDCU_ASSERT_NOW(a_full_stall, !i_cell.ready, o_res.valid && !o_res.ready && (&r_vld),
        "input stalled with room in the pipeline")
    // an item behind a stalled result is kept
    `PDCU_ASSERT_NEXT(a_hold_behind,
        r_vld[NSTG-1] && !o_res.ready && r_vld[NSTG-2], r_vld[NSTG-2],
        "item lost behind stalled output")

endmodule
`default_nettype wire
